/* hw/rtl/grmwh_pkg.sv */
// ----------------------------------------------------------------------------
// grmwh_pkg
// Shared constants for the grid ray marching wall height block.
// ----------------------------------------------------------------------------
`default_nettype none

package grmwh_pkg;

  localparam int MAP_COLS    = 32;
  localparam int MAP_ROWS    = 32;
  localparam int TILE_PIXELS = 64;
  localparam int SCREEN_ROWS = 480;
  localparam int ANGLE_STEPS = 4096;

  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CX_W      = $clog2(MAP_COLS);
  localparam int CY_W      = $clog2(MAP_ROWS);

  localparam int STEP_LIMIT = 4095;
  localparam int HEIGHT_MAX = 65535;

  // Ray position, signed Q.16, wide enough for the start plus 4095 full steps.
  localparam int POS_W   = 30;
  localparam int TILE_SH = 16 + $clog2(TILE_PIXELS);
  localparam int PH_SH   = 16 - $clog2(ANGLE_STEPS);

  // Quarter-wave polynomial coefficients (Q20).
  localparam int POLY_A = 1647099;
  localparam int POLY_B = 677343;
  localparam int POLY_C = 83565;
  localparam int POLY_D = 4909;

  localparam int NUM_VAL = SCREEN_ROWS * 16384;
  localparam int NUM_W   = $clog2(NUM_VAL + 1);
  localparam int DEN_W   = 27;

  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_ANGLE = 2'd2;

  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/grmwh_ram.sv */
// ----------------------------------------------------------------------------
// grmwh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module grmwh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/grid_ray_march_wall_height.sv */
// ----------------------------------------------------------------------------
// grid_ray_march_wall_height
// Marches a ray over a one-bit wall map in unit pixel steps and reports the
// hit point, the distance and a fisheye-corrected wall height.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  in_     | slave     | tuser: operation; tdata: ray_dir, cell_x, cell_y, cell_wall
//  out_    | master    | tuser: hit; tdata: hit_x, hit_y, step_count, height
//  cfg_    | write     | player_x, player_y, player_angle
//
// A cell write goes into the map as it is accepted. A cast runs sine/cosine
// work on the shared multiplier, then one march step per cycle, then, on a
// hit, the corrected cosine, one multiply and the divider.
// After reset a clearing pass over all 1024 cells loads the map border; no word is
// accepted meanwhile. A stalled result holds the next cast in its output state.
`default_nettype none

module grid_ray_march_wall_height (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // ray_dir[11:0], cell_x[16:12], cell_y[21:17], cell_wall[22], zero[23]
  input  wire logic [grmwh_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation[0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // hit_x[10:0], hit_y[21:11], step_count[33:22], height[49:34], zero[55:50]
  output logic      [grmwh_pkg::OUT_DATA_W-1:0]   out_tdata,
  // hit[0]
  output logic                                    out_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [grmwh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [grmwh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int POS_W  = grmwh_pkg::POS_W;
  localparam int ADDR_W = grmwh_pkg::ADDR_W;
  localparam int CXX_W  = POS_W - grmwh_pkg::TILE_SH;
  localparam logic signed [POS_W-1:0] NEG_TILE =
    -POS_W'(grmwh_pkg::TILE_PIXELS * 65536);
  localparam logic [grmwh_pkg::NUM_W-1:0] NUM = grmwh_pkg::NUM_W'(grmwh_pkg::NUM_VAL);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TRIG, S_START, S_MARCH, S_HMUL, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic              outside;
    logic [ADDR_W-1:0] addr;
  } cell_t;

  state_t                            state_r;
  logic [grmwh_pkg::CX_W-1:0]        clr_x_r;
  logic [grmwh_pkg::CY_W-1:0]        clr_y_r;
  logic [18:0]                       player_x_r, player_y_r;
  logic [11:0]                       player_angle_r, ray_r;
  logic signed [POS_W-1:0]           pos_x_r, pos_y_r, dx_r, dy_r;
  logic [11:0]                       steps_r;
  logic [1:0]                        job_r;
  logic [2:0]                        k_r;
  logic [grmwh_pkg::MUL_A_W-1:0]     z_r, z2_r, cd_r;
  logic                              neg_r, hit_r;
  logic [grmwh_pkg::PROD_W-1:0]      prod_r;
  logic [grmwh_pkg::DEN_W-1:0]       rem_r;
  logic [grmwh_pkg::NUM_W-1:0]       quo_r;
  logic [$clog2(grmwh_pkg::NUM_W)-1:0] div_cnt_r;
  logic [15:0]                       height_r;
  logic                              out_valid_r, out_user_r;
  logic [grmwh_pkg::OUT_DATA_W-1:0]  out_data_r;

  function automatic cell_t cell_of(logic signed [POS_W-1:0] px,
                                    logic signed [POS_W-1:0] py);
    cell_t                      c;
    logic [CXX_W-1:0]           ux, uy;
    logic [grmwh_pkg::CX_W-1:0] ix;
    logic [grmwh_pkg::CY_W-1:0] iy;
    logic                       ox, oy;
    ux = px[POS_W-1:grmwh_pkg::TILE_SH];
    uy = py[POS_W-1:grmwh_pkg::TILE_SH];
    // Indices truncate toward zero, so a slightly negative position is cell 0.
    ox = px[POS_W-1] ? (px <= NEG_TILE) : (32'(ux) >= grmwh_pkg::MAP_COLS);
    oy = py[POS_W-1] ? (py <= NEG_TILE) : (32'(uy) >= grmwh_pkg::MAP_ROWS);
    ix = px[POS_W-1] ? '0 : ux[grmwh_pkg::CX_W-1:0];
    iy = py[POS_W-1] ? '0 : uy[grmwh_pkg::CY_W-1:0];
    c.outside = ox | oy;
    c.addr = ADDR_W'(32'(iy) * grmwh_pkg::MAP_COLS + 32'(ix));
    return c;
  endfunction

  function automatic logic [10:0] clamp_pixel(logic signed [POS_W-1:0] p);
    logic [POS_W-17:0] v;
    v = p[POS_W-1:16];
    if (p[POS_W-1]) begin
      return 11'd0;
    end else if (32'(v) > 2047) begin
      return 11'd2047;
    end
    return v[10:0];
  endfunction

  // Shared multiplier and the polynomial subtract that feeds it.
  logic [grmwh_pkg::MUL_A_W-1:0] mul_a, z2_c;
  logic [grmwh_pkg::MUL_B_W-1:0] mul_b, poly_k, poly_c;
  logic [21:0]                   prod_sh;
  logic [15:0]                   phase;
  logic [11:0]                   diff;
  logic [14:0]                   z_c;
  logic [14:0]                   sval;
  logic signed [15:0]            sval_s;

  assign prod_sh = prod_r[35:14];
  assign z2_c    = prod_sh[grmwh_pkg::MUL_A_W-1:0];
  assign diff    = ray_r - player_angle_r;

  always_comb begin
    unique case (k_r)
      3'd3:    poly_k = grmwh_pkg::MUL_B_W'(grmwh_pkg::POLY_C);
      3'd4:    poly_k = grmwh_pkg::MUL_B_W'(grmwh_pkg::POLY_B);
      default: poly_k = grmwh_pkg::MUL_B_W'(grmwh_pkg::POLY_A);
    endcase
    poly_c = poly_k - prod_sh[grmwh_pkg::MUL_B_W-1:0];
  end

  always_comb begin
    mul_a = z_r;
    mul_b = grmwh_pkg::MUL_B_W'(z_r);
    if (state_r == S_HMUL) begin
      mul_a = cd_r;
      mul_b = grmwh_pkg::MUL_B_W'(steps_r);
    end else begin
      case (k_r)
        3'd2:    begin mul_a = z2_c; mul_b = grmwh_pkg::MUL_B_W'(grmwh_pkg::POLY_D); end
        3'd3,
        3'd4:    begin mul_a = z2_r; mul_b = poly_c; end
        3'd5:    begin mul_a = z_r;  mul_b = poly_c; end
        default: ;
      endcase
    end
  end

  // Phase of the current polynomial sine evaluation; a cosine is the sine a quarter turn on.
  always_comb begin
    unique case (job_r)
      2'd1:    phase = 16'(ray_r) << grmwh_pkg::PH_SH;
      2'd2:    phase = (16'(diff) << grmwh_pkg::PH_SH) + 16'd16384;
      default: phase = (16'(ray_r) << grmwh_pkg::PH_SH) + 16'd16384;
    endcase
    z_c = phase[14] ? (15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
    sval = (z_r == 15'd16384) ? 15'd16384 : 15'(prod_r[34:20]);
    sval_s = neg_r ? -16'(sval) : 16'(sval);
  end

  // March datapath.
  logic signed [POS_W-1:0] nx, ny;
  cell_t                   cur_cell, rd_cell;
  logic                    map_bit;

  assign nx = pos_x_r + dx_r;
  assign ny = pos_y_r + dy_r;
  assign cur_cell = cell_of(pos_x_r, pos_y_r);
  assign rd_cell  = (state_r == S_MARCH) ? cell_of(nx, ny) : cur_cell;

  // Map write port: clearing pass first, then cell writes.
  logic                    in_acc, ram_we, ram_wd, border;
  logic [ADDR_W-1:0]       ram_wa;
  logic [4:0]              wcx, wcy;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign wcx       = in_tdata[16:12];
  assign wcy       = in_tdata[21:17];
  assign border    = (clr_x_r == '0) || (32'(clr_x_r) == grmwh_pkg::MAP_COLS - 1) ||
                     (clr_y_r == '0) || (32'(clr_y_r) == grmwh_pkg::MAP_ROWS - 1);

  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = ADDR_W'(32'(clr_y_r) * grmwh_pkg::MAP_COLS + 32'(clr_x_r));
      ram_wd = border;
    end else begin
      ram_we = in_acc && (in_tuser == grmwh_pkg::OP_WRITE) &&
               (32'(wcx) < grmwh_pkg::MAP_COLS) && (32'(wcy) < grmwh_pkg::MAP_ROWS);
      ram_wa = ADDR_W'(32'(wcy) * grmwh_pkg::MAP_COLS + 32'(wcx));
      ram_wd = in_tdata[22];
    end
  end

  grmwh_ram #(
    .WIDTH (1),
    .DEPTH (grmwh_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (rd_cell.addr),
    .rdata (map_bit)
  );

  // Restoring divider step.
  logic [grmwh_pkg::DEN_W:0]   trial;
  logic [grmwh_pkg::DEN_W-1:0] den;
  logic                        qbit;
  logic [grmwh_pkg::NUM_W-1:0] quo_nxt;

  assign den     = prod_r[grmwh_pkg::DEN_W-1:0];
  assign trial   = {rem_r, NUM[div_cnt_r]};
  assign qbit    = trial >= {1'b0, den};
  assign quo_nxt = {quo_r[grmwh_pkg::NUM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_x_r        <= '0;
      clr_y_r        <= '0;
      player_x_r     <= 19'd81920;
      player_y_r     <= 19'd61440;
      player_angle_r <= '0;
      out_valid_r    <= 1'b0;
      job_r          <= '0;
      k_r            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          grmwh_pkg::REG_PLAYER_X:     player_x_r     <= cfg_wdata;
          grmwh_pkg::REG_PLAYER_Y:     player_y_r     <= cfg_wdata;
          grmwh_pkg::REG_PLAYER_ANGLE: player_angle_r <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          if (32'(clr_x_r) == grmwh_pkg::MAP_COLS - 1) begin
            clr_x_r <= '0;
            clr_y_r <= clr_y_r + 1'b1;
            if (32'(clr_y_r) == grmwh_pkg::MAP_ROWS - 1) begin
              state_r <= S_IDLE;
            end
          end else begin
            clr_x_r <= clr_x_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_tuser == grmwh_pkg::OP_CAST)) begin
            ray_r   <= in_tdata[11:0];
            pos_x_r <= POS_W'(player_x_r) <<< 8;
            pos_y_r <= POS_W'(player_y_r) <<< 8;
            steps_r <= '0;
            job_r   <= 2'd0;
            k_r     <= 3'd0;
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (k_r != 3'd6) begin
            k_r    <= k_r + 1'b1;
            prod_r <= grmwh_pkg::PROD_W'(mul_a) * grmwh_pkg::PROD_W'(mul_b);
          end
          case (k_r)
            3'd0: begin
              z_r   <= z_c;
              neg_r <= phase[15];
            end
            3'd2: z2_r <= z2_c;
            3'd6: begin
              k_r   <= 3'd0;
              job_r <= job_r + 1'b1;
              unique case (job_r)
                2'd0: dx_r <= POS_W'(sval_s) <<< 2;
                2'd1: begin
                  dy_r    <= POS_W'(sval_s) <<< 2;
                  state_r <= S_START;
                end
                default: begin
                  cd_r <= sval;
                  if (!neg_r && (sval != '0)) begin
                    state_r <= S_HMUL;
                  end else begin
                    height_r <= 16'(grmwh_pkg::HEIGHT_MAX);
                    state_r  <= S_OUT;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
        S_START: state_r <= S_MARCH;
        S_MARCH: begin
          // map_bit belongs to the current position; the next one is in flight.
          if (cur_cell.outside || (32'(steps_r) >= grmwh_pkg::STEP_LIMIT && !map_bit)) begin
            hit_r    <= 1'b0;
            height_r <= '0;
            state_r  <= S_OUT;
          end else if (map_bit) begin
            hit_r <= 1'b1;
            if (steps_r == '0) begin
              height_r <= 16'(grmwh_pkg::HEIGHT_MAX);
              state_r  <= S_OUT;
            end else begin
              k_r     <= 3'd0;
              state_r <= S_TRIG;
            end
          end else begin
            pos_x_r <= nx;
            pos_y_r <= ny;
            steps_r <= steps_r + 1'b1;
          end
        end
        S_HMUL: begin
          prod_r    <= grmwh_pkg::PROD_W'(mul_a) * grmwh_pkg::PROD_W'(mul_b);
          rem_r     <= '0;
          quo_r     <= '0;
          div_cnt_r <= ($clog2(grmwh_pkg::NUM_W))'(grmwh_pkg::NUM_W - 1);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= qbit ? grmwh_pkg::DEN_W'(trial - {1'b0, den})
                            : grmwh_pkg::DEN_W'(trial);
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            height_r <= (32'(quo_nxt) > grmwh_pkg::HEIGHT_MAX) ?
                        16'(grmwh_pkg::HEIGHT_MAX) : quo_nxt[15:0];
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= hit_r;
            out_data_r  <= {6'd0, height_r, steps_r,
                            hit_r ? clamp_pixel(pos_y_r) : 11'd0,
                            hit_r ? clamp_pixel(pos_x_r) : 11'd0};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("word accepted during map clearing pass");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[49:34] == '0 && out_tdata[21:0] == '0))
    else $error("miss result carries a hit point or height");

  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARCH) |-> (32'(steps_r) <= grmwh_pkg::STEP_LIMIT))
    else $error("march ran past the step limit");

  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_tdata[33:22] == '0) |->
    (out_tdata[49:34] == 16'(grmwh_pkg::HEIGHT_MAX)))
    else $error("hit at zero distance without saturated height");

endmodule

`default_nettype wire
